FILE: hdl/fpfa_pkg.sv
// shared types and codes of the fixed partition fit allocator
package fpfa_pkg;

    localparam int CMD_W      = 2;
    localparam int SIZE_KB_W  = 16;
    localparam int STATUS_W   = 2;
    localparam int PROC_W     = 8;
    localparam int PART_W     = 4;
    localparam int WASTE_W    = 16;
    localparam int FRAG_W     = 20;
    localparam int MODE_W     = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PLACE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REPORT = 2'd3;

    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

    localparam logic [PROC_W-1:0] PROC_MAX = 8'd255;
    localparam logic [FRAG_W-1:0] FRAG_MAX = 20'hFFFFF;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [SIZE_KB_W-1:0] size_kb;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PROC_W-1:0]   process_index;
        logic [PART_W-1:0]   partition_index;
        logic [WASTE_W-1:0]  wastage_kb;
        logic [FRAG_W-1:0]   internal_frag_kb;
        logic [FRAG_W-1:0]   external_frag_kb;
    } out_item_t;

endpackage

FILE: hdl/fixed_partition_fit_allocator.sv
// fixed partition allocator: capacity ram, scan sequencer and result register
// order: a load goes from idle to the result state; place and finish first scan
//   every loaded partition through the capacity ram, then reach the result state
// flow: one item at a time; next item accepted the cycle after the result
//   moves to the output register, which waits while out_stall holds a pending beat
// reset: clears fit mode, busy marks, partition count, process counter and totals;
//   capacity ram contents stay undefined until loaded
module fixed_partition_fit_allocator #(
    parameter int MAX_PARTITIONS = 16,
    parameter int SIZE_BITS      = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  fpfa_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output fpfa_pkg::out_item_t  out_data
);

    localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
    localparam int SUM_W = ((SIZE_BITS > fpfa_pkg::FRAG_W) ? SIZE_BITS : fpfa_pkg::FRAG_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_RESULT = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [fpfa_pkg::MODE_W-1:0]     mode_reg, mode_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [fpfa_pkg::PROC_W-1:0]     proc_reg, proc_next;
    logic [fpfa_pkg::FRAG_W-1:0]     internal_reg, internal_next;
    logic [MAX_PARTITIONS-1:0]       busy_reg, busy_next;
    logic [CNT_W-1:0]                ptr_reg, ptr_next;
    logic                            rd_valid_reg, rd_valid_next;
    logic                            found_reg, found_next;
    logic                            out_valid_reg, out_valid_next;

    logic [fpfa_pkg::CMD_W-1:0]      cmd_reg, cmd_next;
    logic [SIZE_BITS-1:0]            size_reg, size_next;
    logic [IDX_W-1:0]                rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]                pick_reg, pick_next;
    logic [SIZE_BITS-1:0]            pick_cap_reg, pick_cap_next;
    logic [fpfa_pkg::FRAG_W-1:0]     ext_reg, ext_next;
    fpfa_pkg::out_item_t             res_reg, res_next;
    fpfa_pkg::out_item_t             out_data_reg, out_data_next;

    logic                            in_fire;
    logic                            out_free;
    logic                            issue;
    logic                            scan_end;
    logic                            fits;
    logic [47:0]                     size_wide;
    logic [SIZE_BITS-1:0]            size_in;
    logic                            ram_wr_en;
    logic [IDX_W-1:0]                ram_wr_addr;
    logic [SIZE_BITS-1:0]            rd_data;
    logic [SIZE_BITS-1:0]            waste;
    logic [SUM_W-1:0]                int_sum;
    logic [SUM_W-1:0]                ext_sum;
    logic [31:0]                     pick_wide;
    logic [31:0]                     count_wide;
    logic [31:0]                     waste_wide;
    logic [fpfa_pkg::FRAG_W-1:0]     int_sat;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign size_wide = {32'd0, in_data.size_kb};
    assign size_in   = size_wide[SIZE_BITS-1:0];

    assign issue    = (state_reg == S_SCAN) && (ptr_reg < count_reg);
    assign scan_end = (state_reg == S_SCAN) && (ptr_reg == count_reg) && !rd_valid_reg;
    assign fits     = !busy_reg[rd_idx_reg] && (rd_data >= size_reg);

    assign ram_wr_en   = in_fire && (in_data.command == fpfa_pkg::CMD_LOAD)
                         && (count_reg < CNT_W'(MAX_PARTITIONS));
    assign ram_wr_addr = count_reg[IDX_W-1:0];

    assign waste      = pick_cap_reg - size_reg;
    assign int_sum    = SUM_W'(internal_reg) + SUM_W'(waste);
    assign int_sat    = (int_sum > SUM_W'(fpfa_pkg::FRAG_MAX)) ? fpfa_pkg::FRAG_MAX
                                                               : int_sum[fpfa_pkg::FRAG_W-1:0];
    assign ext_sum    = SUM_W'(ext_reg) + SUM_W'(rd_data);
    assign pick_wide  = 32'(pick_reg);
    assign count_wide = 32'(count_reg);
    assign waste_wide = 32'(waste);

    fpfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_PARTITIONS)
    ) u_cap_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (size_in),
        .rd_en   (issue),
        .rd_addr (ptr_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        count_next     = count_reg;
        proc_next      = proc_reg;
        internal_next  = internal_reg;
        busy_next      = busy_reg;
        ptr_next       = ptr_reg;
        rd_valid_next  = issue;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        size_next      = size_reg;
        rd_idx_next    = ptr_reg[IDX_W-1:0];
        pick_next      = pick_reg;
        pick_cap_next  = pick_cap_reg;
        ext_next       = ext_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;

        if (cfg_valid && cfg_ready)
        begin
            mode_next = cfg_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (issue)
        begin
            ptr_next = ptr_reg + 1'b1;
        end

        // one capacity per beat of the ram
        if (rd_valid_reg)
        begin
            if (cmd_reg == fpfa_pkg::CMD_PLACE)
            begin
                if (fits)
                begin
                    if (!found_reg)
                    begin
                        found_next    = 1'b1;
                        pick_next     = rd_idx_reg;
                        pick_cap_next = rd_data;
                    end
                    else if ((mode_reg == fpfa_pkg::FIT_BEST) && (rd_data < pick_cap_reg))
                    begin
                        pick_next     = rd_idx_reg;
                        pick_cap_next = rd_data;
                    end
                    else if ((mode_reg == fpfa_pkg::FIT_WORST) && (rd_data > pick_cap_reg))
                    begin
                        pick_next     = rd_idx_reg;
                        pick_cap_next = rd_data;
                    end
                end
            end
            else if (!busy_reg[rd_idx_reg])
            begin
                ext_next = (ext_sum > SUM_W'(fpfa_pkg::FRAG_MAX))
                           ? fpfa_pkg::FRAG_MAX : ext_sum[fpfa_pkg::FRAG_W-1:0];
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next   = in_data.command;
                    size_next  = size_in;
                    ptr_next   = '0;
                    found_next = 1'b0;
                    ext_next   = '0;
                    res_next.status           = fpfa_pkg::ST_OK;
                    res_next.process_index    = '0;
                    res_next.partition_index  = '0;
                    res_next.wastage_kb       = '0;
                    res_next.internal_frag_kb = internal_reg;
                    res_next.external_frag_kb = '0;
                    case (in_data.command)
                        fpfa_pkg::CMD_LOAD:
                        begin
                            if (ram_wr_en)
                            begin
                                res_next.partition_index = count_wide[fpfa_pkg::PART_W-1:0];
                                busy_next[ram_wr_addr]   = 1'b0;
                                count_next               = count_reg + 1'b1;
                            end
                            else
                            begin
                                res_next.status = fpfa_pkg::ST_FULL;
                            end
                            state_next = S_RESULT;
                        end
                        fpfa_pkg::CMD_PLACE, fpfa_pkg::CMD_FINISH:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    res_next.wastage_kb       = '0;
                    res_next.partition_index  = '0;
                    res_next.external_frag_kb = '0;
                    res_next.internal_frag_kb = internal_reg;
                    if (cmd_reg == fpfa_pkg::CMD_PLACE)
                    begin
                        res_next.process_index = proc_reg;
                        if (proc_reg != fpfa_pkg::PROC_MAX)
                        begin
                            proc_next = proc_reg + 1'b1;
                        end
                        if (found_reg)
                        begin
                            res_next.status           = fpfa_pkg::ST_OK;
                            res_next.partition_index  = pick_wide[fpfa_pkg::PART_W-1:0];
                            res_next.wastage_kb       = waste_wide[fpfa_pkg::WASTE_W-1:0];
                            res_next.internal_frag_kb = int_sat;
                            internal_next             = int_sat;
                            busy_next[pick_reg]       = 1'b1;
                        end
                        else
                        begin
                            res_next.status = fpfa_pkg::ST_NO_FIT;
                        end
                    end
                    else
                    begin
                        res_next.status           = fpfa_pkg::ST_REPORT;
                        res_next.process_index    = '0;
                        res_next.external_frag_kb = ext_reg;
                        busy_next                 = '0;
                        proc_next                 = '0;
                        internal_next             = '0;
                    end
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= fpfa_pkg::FIT_FIRST;
            count_reg     <= '0;
            proc_reg      <= '0;
            internal_reg  <= '0;
            busy_reg      <= '0;
            ptr_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            proc_reg      <= proc_next;
            internal_reg  <= internal_next;
            busy_reg      <= busy_next;
            ptr_reg       <= ptr_next;
            rd_valid_reg  <= rd_valid_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        size_reg     <= size_next;
        rd_idx_reg   <= rd_idx_next;
        pick_reg     <= pick_next;
        pick_cap_reg <= pick_cap_next;
        ext_reg      <= ext_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PARTITIONS))
        else $error("partition count beyond table depth");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == S_SCAN))
        else $error("ram read data outside a scan");

    a_place_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_end && (cmd_reg == fpfa_pkg::CMD_PLACE) && found_reg)
        |=> busy_reg[$past(pick_reg)])
        else $error("placed partition not marked busy");

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_end && (cmd_reg == fpfa_pkg::CMD_FINISH))
        |=> ((busy_reg == '0) && (internal_reg == '0) && (proc_reg == '0)))
        else $error("finish left allocation state behind");

    a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESULT))
        else $error("output beat not loaded from result stage");

endmodule

FILE: hdl/fpfa_ram.sv
// generic single write port, single read port ram with registered read
module fpfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: tb/sv/fixed_partition_fit_allocator_tb.sv
// testbench for the fixed partition fit allocator: directed plan, random phases, scoreboard
module fixed_partition_fit_allocator_tb;

    localparam int          MAX_PARTITIONS = 16;
    localparam int          SETTLE_CYCLES  = MAX_PARTITIONS + 8;
    localparam int          HOLD_CYCLES    = 300;
    localparam int unsigned CYCLE_LIMIT    = 200000;

    localparam logic [fpfa_pkg::CMD_W-1:0]  CMD_NONE   = 2'd3;
    localparam logic [fpfa_pkg::MODE_W-1:0] FIT_UNUSED = 2'd3;

    typedef struct packed {
        fpfa_pkg::in_item_t  item;
        logic                typed;
        fpfa_pkg::out_item_t want;
    } plan_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_data;
    logic                in_valid;
    logic                in_stall;
    fpfa_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_stall;
    fpfa_pkg::out_item_t out_data;

    // allocator state as predicted
    logic [fpfa_pkg::MODE_W-1:0]    fit_mode_now;
    logic [fpfa_pkg::SIZE_KB_W-1:0] part_capacity [MAX_PARTITIONS];
    bit                             part_busy [MAX_PARTITIONS];
    int                             part_cnt;
    logic [fpfa_pkg::PROC_W-1:0]    proc_cnt;
    int unsigned                    int_total;

    fpfa_pkg::out_item_t awaited_results [$];
    fpfa_pkg::out_item_t oldest_result;
    int          errors = 0;
    int unsigned cycle_count = 0;
    bit          no_idle = 1'b0;
    bit          hold_req = 1'b0;

    plan_row_t directed_plan [25] = '{
        '{'{fpfa_pkg::CMD_PLACE,  16'd0},     1'b1,
          '{fpfa_pkg::ST_NO_FIT, 8'd0, 4'd0, 16'd0, 20'd0, 20'd0}},
        '{'{fpfa_pkg::CMD_FINISH, 16'd0},     1'b1,
          '{fpfa_pkg::ST_REPORT, 8'd0, 4'd0, 16'd0, 20'd0, 20'd0}},
        '{'{CMD_NONE,             16'hFFFF},  1'b0, '0},
        '{'{fpfa_pkg::CMD_LOAD,   16'hFFFF},  1'b1,
          '{fpfa_pkg::ST_OK, 8'd0, 4'd0, 16'd0, 20'd0, 20'd0}},
        '{'{fpfa_pkg::CMD_LOAD,   16'd0},     1'b1,
          '{fpfa_pkg::ST_OK, 8'd0, 4'd1, 16'd0, 20'd0, 20'd0}},
        '{'{fpfa_pkg::CMD_LOAD,   16'd100},   1'b1,
          '{fpfa_pkg::ST_OK, 8'd0, 4'd2, 16'd0, 20'd0, 20'd0}},
        '{'{fpfa_pkg::CMD_LOAD,   16'd100},   1'b1,
          '{fpfa_pkg::ST_OK, 8'd0, 4'd3, 16'd0, 20'd0, 20'd0}},
        '{'{fpfa_pkg::CMD_PLACE,  16'd0},     1'b1,
          '{fpfa_pkg::ST_OK, 8'd0, 4'd0, 16'hFFFF, 20'h0FFFF, 20'd0}},
        '{'{fpfa_pkg::CMD_PLACE,  16'hFFFF},  1'b1,
          '{fpfa_pkg::ST_NO_FIT, 8'd1, 4'd0, 16'd0, 20'h0FFFF, 20'd0}},
        '{'{fpfa_pkg::CMD_PLACE,  16'd100},   1'b0, '0},
        '{'{fpfa_pkg::CMD_PLACE,  16'd0},     1'b0, '0},
        '{'{fpfa_pkg::CMD_FINISH, 16'h5A5A},  1'b0, '0},
        '{'{fpfa_pkg::CMD_LOAD,   16'd1},     1'b0, '0},
        '{'{fpfa_pkg::CMD_LOAD,   16'd300},   1'b0, '0},
        '{'{fpfa_pkg::CMD_LOAD,   16'd50},    1'b0, '0},
        '{'{fpfa_pkg::CMD_LOAD,   16'd4096},  1'b0, '0},
        '{'{fpfa_pkg::CMD_LOAD,   16'hFFFF},  1'b0, '0},
        '{'{fpfa_pkg::CMD_LOAD,   16'd7},     1'b0, '0},
        '{'{fpfa_pkg::CMD_LOAD,   16'd1000},  1'b0, '0},
        '{'{fpfa_pkg::CMD_LOAD,   16'd20000}, 1'b0, '0},
        '{'{fpfa_pkg::CMD_LOAD,   16'd2},     1'b0, '0},
        '{'{fpfa_pkg::CMD_LOAD,   16'd32768}, 1'b0, '0},
        '{'{fpfa_pkg::CMD_LOAD,   16'd500},   1'b0, '0},
        '{'{fpfa_pkg::CMD_LOAD,   16'hFFFE},  1'b0, '0},
        '{'{fpfa_pkg::CMD_LOAD,   16'd5},     1'b1,
          '{fpfa_pkg::ST_FULL, 8'd0, 4'd0, 16'd0, 20'd0, 20'd0}}
    };

    fixed_partition_fit_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic bit compute_allocation(input fpfa_pkg::in_item_t item,
                                              output fpfa_pkg::out_item_t res);
        bit                             found;
        int                             pick;
        int unsigned                    free_sum;
        logic [fpfa_pkg::SIZE_KB_W-1:0] sz;
        res = '0;
        sz = item.size_kb;
        found = 1'b0;
        pick = 0;
        free_sum = 0;
        case (item.command)
            fpfa_pkg::CMD_LOAD:
            begin
                res.internal_frag_kb = int_total[fpfa_pkg::FRAG_W-1:0];
                if (part_cnt >= MAX_PARTITIONS)
                    res.status = fpfa_pkg::ST_FULL;
                else
                begin
                    part_capacity[part_cnt] = sz;
                    part_busy[part_cnt] = 1'b0;
                    res.status = fpfa_pkg::ST_OK;
                    res.partition_index = part_cnt[fpfa_pkg::PART_W-1:0];
                    part_cnt++;
                end
                return 1'b1;
            end
            fpfa_pkg::CMD_PLACE:
            begin
                for (int i = 0; i < part_cnt; i++)
                begin
                    if (part_busy[i] || part_capacity[i] < sz)
                        continue;
                    if (!found)
                    begin
                        found = 1'b1;
                        pick = i;
                        if (fit_mode_now != fpfa_pkg::FIT_BEST
                            && fit_mode_now != fpfa_pkg::FIT_WORST)
                            break;
                    end
                    else if (fit_mode_now == fpfa_pkg::FIT_BEST
                             && part_capacity[i] < part_capacity[pick])
                        pick = i;
                    else if (fit_mode_now == fpfa_pkg::FIT_WORST
                             && part_capacity[i] > part_capacity[pick])
                        pick = i;
                end
                res.process_index = proc_cnt;
                if (proc_cnt != fpfa_pkg::PROC_MAX)
                    proc_cnt++;
                if (!found)
                    res.status = fpfa_pkg::ST_NO_FIT;
                else
                begin
                    res.status = fpfa_pkg::ST_OK;
                    res.partition_index = pick[fpfa_pkg::PART_W-1:0];
                    res.wastage_kb = part_capacity[pick] - sz;
                    part_busy[pick] = 1'b1;
                    int_total = int_total + 32'(res.wastage_kb);
                    if (int_total > 32'(fpfa_pkg::FRAG_MAX))
                        int_total = 32'(fpfa_pkg::FRAG_MAX);
                end
                res.internal_frag_kb = int_total[fpfa_pkg::FRAG_W-1:0];
                return 1'b1;
            end
            fpfa_pkg::CMD_FINISH:
            begin
                for (int i = 0; i < part_cnt; i++)
                begin
                    if (!part_busy[i])
                    begin
                        free_sum = free_sum + 32'(part_capacity[i]);
                        if (free_sum > 32'(fpfa_pkg::FRAG_MAX))
                            free_sum = 32'(fpfa_pkg::FRAG_MAX);
                    end
                end
                res.status = fpfa_pkg::ST_REPORT;
                res.internal_frag_kb = int_total[fpfa_pkg::FRAG_W-1:0];
                res.external_frag_kb = free_sum[fpfa_pkg::FRAG_W-1:0];
                for (int i = 0; i < MAX_PARTITIONS; i++)
                    part_busy[i] = 1'b0;
                proc_cnt = '0;
                int_total = 0;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %h", $time, out_data);
                errors++;
            end
            else
            begin
                oldest_result = awaited_results.pop_front();
                check_field("status", 32'(oldest_result.status), 32'(out_data.status));
                check_field("process_index", 32'(oldest_result.process_index),
                            32'(out_data.process_index));
                check_field("partition_index", 32'(oldest_result.partition_index),
                            32'(out_data.partition_index));
                check_field("wastage_kb", 32'(oldest_result.wastage_kb),
                            32'(out_data.wastage_kb));
                check_field("internal_frag_kb", 32'(oldest_result.internal_frag_kb),
                            32'(out_data.internal_frag_kb));
                check_field("external_frag_kb", 32'(oldest_result.external_frag_kb),
                            32'(out_data.external_frag_kb));
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                out_stall = 1'b0;
            end
            else
                out_stall = !no_idle && ($urandom_range(99) < 13);
        end
    end

    task automatic send_beat(input fpfa_pkg::in_item_t item, input logic typed,
                             input fpfa_pkg::out_item_t want);
        fpfa_pkg::out_item_t predicted;
        int                  gap;
        @(negedge clk);
        if (!no_idle && $urandom_range(99) < 13)
        begin
            in_valid = 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge clk);
        end
        in_data = item;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (compute_allocation(item, predicted))
            awaited_results.push_back(typed ? want : predicted);
    endtask

    task automatic let_block_settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_fit_mode(input logic [fpfa_pkg::MODE_W-1:0] mode);
        let_block_settle();
        @(negedge clk);
        cfg_data = mode;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        fit_mode_now = mode;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_phase(input logic [fpfa_pkg::MODE_W-1:0] mode, input int beats,
                             input bit places_only, input bit quiet, input bit hold);
        fpfa_pkg::in_item_t             item;
        int                             done;
        int                             roll;
        int                             slot;
        int                             trim;
        logic [fpfa_pkg::SIZE_KB_W-1:0] cap;
        write_fit_mode(mode);
        no_idle = quiet;
        hold_req = hold;
        done = 0;
        while (done < beats)
        begin
            roll = $urandom_range(99);
            item.size_kb = 16'($urandom_range(16'hFFFF));
            if (places_only || roll >= 18)
            begin
                item.command = fpfa_pkg::CMD_PLACE;
                slot = $urandom_range(part_cnt - 1);
                cap = part_capacity[slot];
                trim = $urandom_range(3);
                roll = $urandom_range(99);
                if (roll < 40)
                    item.size_kb = (cap >= 16'(trim)) ? cap - 16'(trim) : '0;
                else if (roll < 60)
                    item.size_kb = cap;
                else if (roll < 70)
                    item.size_kb = '0;
                else if (roll < 80)
                    item.size_kb = 16'($urandom_range(1000));
            end
            else if (roll < 4)
                item.command = CMD_NONE;
            else if (roll < 8)
                item.command = fpfa_pkg::CMD_LOAD;
            else
                item.command = fpfa_pkg::CMD_FINISH;
            send_beat(item, 1'b0, '0);
            if (item.command != CMD_NONE)
                done++;
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        fit_mode_now = fpfa_pkg::FIT_FIRST;
        part_cnt = 0;
        proc_cnt = '0;
        int_total = 0;
        for (int i = 0; i < MAX_PARTITIONS; i++)
        begin
            part_capacity[i] = '0;
            part_busy[i] = 1'b0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_fit_mode(fpfa_pkg::FIT_FIRST);
        foreach (directed_plan[k])
            send_beat(directed_plan[k].item, directed_plan[k].typed, directed_plan[k].want);

        run_phase(fpfa_pkg::FIT_BEST, 60, 1'b0, 1'b1, 1'b0);
        run_phase(fpfa_pkg::FIT_WORST, 60, 1'b0, 1'b0, 1'b1);
        // long run of placements with no finish drives the process counter to its ceiling
        run_phase(FIT_UNUSED, 265, 1'b1, 1'b0, 1'b0);
        run_phase(fpfa_pkg::FIT_FIRST, 50, 1'b0, 1'b0, 1'b0);
        run_phase(fpfa_pkg::FIT_BEST, 45, 1'b0, 1'b0, 1'b0);
        run_phase(fpfa_pkg::FIT_WORST, 45, 1'b0, 1'b0, 1'b0);

        let_block_settle();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
